// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the phase decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define QPD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("Assertion failed in the phase decoder.");

// An implication whose consequent is checked in the cycle after its antecedent.
`define QPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Assertion failed in the phase decoder.");

`endif

// ===== rtl/qpd_pkg.sv =====
// Types and constants shared by the quadrature phase decoder modules.
package qpd_pkg;

  localparam int unsigned PhaseW = 2;
  localparam int unsigned PptW   = 11;
  localparam int unsigned PosW   = 12;
  localparam int unsigned TurnW  = 32;

  localparam logic [PptW-1:0] PptReset = 11'd1200;

  // Phase advance from the previous sample to the current one, modulo four.
  typedef enum logic [PhaseW-1:0] {
    DIFF_SAME  = 2'd0,
    DIFF_RIGHT = 2'd1,
    DIFF_JUMP  = 2'd2,
    DIFF_LEFT  = 2'd3
  } diff_e;

  typedef struct packed {
    logic [PhaseW-1:0] last_phase;
    logic              in_sync;
    logic [PosW-1:0]   step_count;
    logic [TurnW-1:0]  turns;
  } state_t;

  typedef struct packed {
    logic [PosW-1:0]  position;
    logic             moved;
    logic             direction;
    logic             phase_error;
    logic             turn_done;
    logic [TurnW-1:0] turn_count;
  } result_t;

endpackage

// ===== rtl/qpd_step.sv =====
// Combinational next-state and result logic for one phase sample.
module qpd_step (
  input  qpd_pkg::state_t                state_i,
  input  logic [qpd_pkg::PhaseW-1:0]     phase_i,
  input  logic [qpd_pkg::PptW-1:0]       ppt_i,
  output qpd_pkg::state_t                state_o,
  output qpd_pkg::result_t               result_o
);

  logic [qpd_pkg::PhaseW-1:0] diff;
  logic signed [qpd_pkg::PosW:0] lim;
  logic signed [qpd_pkg::PosW:0] neg_lim;
  logic signed [qpd_pkg::PosW:0] cur;
  logic signed [qpd_pkg::PosW:0] inc;
  logic signed [qpd_pkg::PosW:0] dec;
  logic [qpd_pkg::TurnW-1:0]     turns_inc;

  assign diff      = phase_i - state_i.last_phase;
  assign lim       = $signed({2'b00, ppt_i});
  assign neg_lim   = -lim;
  assign cur       = $signed({state_i.step_count[qpd_pkg::PosW-1], state_i.step_count});
  assign inc       = cur + 13'sd1;
  assign dec       = cur - 13'sd1;
  assign turns_inc = state_i.turns + 32'd1;

  always_comb begin
    state_o                = state_i;
    state_o.last_phase     = phase_i;
    result_o               = '0;
    if (!state_i.in_sync) begin
      state_o.in_sync = 1'b1;
    end else begin
      unique case (qpd_pkg::diff_e'(diff))
        qpd_pkg::DIFF_RIGHT: begin
          result_o.moved     = 1'b1;
          result_o.direction = 1'b1;
          if (inc >= lim) begin
            state_o.step_count = '0;
            state_o.turns      = turns_inc;
            result_o.turn_done = 1'b1;
          end else begin
            state_o.step_count = inc[qpd_pkg::PosW-1:0];
          end
        end
        qpd_pkg::DIFF_LEFT: begin
          result_o.moved = 1'b1;
          if (dec <= neg_lim) begin
            state_o.step_count = '0;
            state_o.turns      = turns_inc;
            result_o.turn_done = 1'b1;
          end else begin
            state_o.step_count = dec[qpd_pkg::PosW-1:0];
          end
        end
        qpd_pkg::DIFF_JUMP: begin
          result_o.phase_error = 1'b1;
          state_o.in_sync      = 1'b0;
        end
        default: begin
        end
      endcase
    end
    result_o.position   = state_o.step_count;
    result_o.turn_count = state_o.turns;
  end

endmodule

// ===== rtl/quadrature_phase_decoder.sv =====
// Top level of the quadrature phase decoder.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       in_valid_i / in_stall_o    phase_i
//   out      source     out_valid_o / out_stall_i  position_o, moved_o, direction_o,
//                                                  phase_error_o, turn_done_o, turn_count_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_data_i (pulses per turn)
//
// A sample passes an input register, the decode logic and a result register on its way
// to the output; one sample is taken in every cycle in which the input is not stalled.
// The decoder state is updated as a sample moves into the result register.
// Reset clears the state, the valid flags and sets the turn length to 1200.
// A stall on the output holds the result and, once the input register is full, stalls
// the input in the same cycle.
module quadrature_phase_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [qpd_pkg::PhaseW-1:0]     phase_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [qpd_pkg::PosW-1:0] position_o,
  output logic                           moved_o,
  output logic                           direction_o,
  output logic                           phase_error_o,
  output logic                           turn_done_o,
  output logic [qpd_pkg::TurnW-1:0]      turn_count_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [qpd_pkg::PptW-1:0]       cfg_data_i
);

  logic                       in_vld_q;
  logic [qpd_pkg::PhaseW-1:0] phase_q;
  logic                       out_vld_q;
  qpd_pkg::result_t           res_q;
  qpd_pkg::state_t            state_q;
  qpd_pkg::state_t            state_d;
  qpd_pkg::result_t           res_d;
  logic [qpd_pkg::PptW-1:0]   ppt_q;
  logic                       res_free;
  logic                       advance;
  logic                       in_take;

  assign res_free    = !out_vld_q || !out_stall_i;
  assign advance     = in_vld_q && res_free;
  assign in_stall_o  = in_vld_q && !res_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  qpd_step u_step (
    .state_i  (state_q),
    .phase_i  (phase_q),
    .ppt_i    (ppt_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
      ppt_q     <= qpd_pkg::PptReset;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (res_free) begin
        out_vld_q <= in_vld_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        ppt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      phase_q <= phase_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign position_o    = $signed(res_q.position);
  assign moved_o       = res_q.moved;
  assign direction_o   = res_q.direction;
  assign phase_error_o = res_q.phase_error;
  assign turn_done_o   = res_q.turn_done;
  assign turn_count_o  = res_q.turn_count;

endmodule

// ===== rtl/qpd_checker.sv =====
// Port-level checks on the results of the quadrature phase decoder, with its bind.
`include "assert_macros.svh"

module qpd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [qpd_pkg::PosW-1:0] position_o,
  input logic                            moved_o,
  input logic                            direction_o,
  input logic                            phase_error_o,
  input logic                            turn_done_o,
  input logic [qpd_pkg::TurnW-1:0]       turn_count_o
);

  // A stalled transaction stays offered.
  `QPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Without a counted step there is neither a direction nor a completed turn.
  `QPD_ASSERT(a_idle_flags, clk_i, rst_ni, out_valid_o && !moved_o |-> !direction_o && !turn_done_o)

  // A completed turn always comes from a step and leaves the position at zero.
  `QPD_ASSERT(a_turn_zero, clk_i, rst_ni, out_valid_o && turn_done_o |-> moved_o && position_o == 0)

  // A phase error never counts a step.
  `QPD_ASSERT(a_err_still, clk_i, rst_ni, out_valid_o && phase_error_o |-> !moved_o)

  // The turn count of a stalled transaction does not change.
  `QPD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(turn_count_o))

endmodule

bind quadrature_phase_decoder qpd_checker u_qpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .position_o    (position_o),
  .moved_o       (moved_o),
  .direction_o   (direction_o),
  .phase_error_o (phase_error_o),
  .turn_done_o   (turn_done_o),
  .turn_count_o  (turn_count_o)
);
